>>> hdl/bxx_pkg.sv
// Shared types for the byte-wide XXTEA block cipher.
package bxx_pkg;

	typedef enum logic [1:0] {
		OP_ENC  = 2'd0,
		OP_DEC  = 2'd1,
		OP_PASS = 2'd2
	} op_t;

	typedef struct packed {
		logic [7:0] data;
		op_t        op;
		logic       last;
	} qword_t;

endpackage

>>> hdl/bxx_if.sv
// Valid/ready channel interfaces for the cipher's input and result words.
interface bxx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic [1:0] op;

	modport source(output valid, output in_byte, output op, input ready);
	modport sink(input valid, input in_byte, input op, output ready);
endinterface

interface bxx_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_block;

	modport source(output valid, output out_byte, output last_of_block, input ready);
	modport sink(input valid, input out_byte, input last_of_block, output ready);
endinterface

>>> hdl/bxx_front.sv
// Front end: accepts input words, tags the final byte of each block and decodes the op.
module bxx_front import bxx_pkg::*; #(
	parameter int BLOCK_BYTES = 32
) (
	input  logic   clk,
	input  logic   arst_n,
	bxx_in_if.sink byte_stream,
	input  logic   q_full,
	output logic   push,
	output qword_t push_word
);

	localparam int IDXW = $clog2(BLOCK_BYTES);
	localparam logic [IDXW-1:0] LAST_IDX = IDXW'(BLOCK_BYTES - 1);

	logic [IDXW-1:0] fill_q;

	assign byte_stream.ready = !q_full;
	assign push = byte_stream.valid && !q_full;

	always_comb begin
		push_word.data = byte_stream.in_byte;
		push_word.last = (fill_q == LAST_IDX);
		case (op_t'(byte_stream.op))
			OP_ENC:  push_word.op = OP_ENC;
			OP_DEC:  push_word.op = OP_DEC;
			default: push_word.op = OP_PASS;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (push) begin
			if (fill_q == LAST_IDX) begin
				fill_q <= '0;
			end else begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

endmodule

>>> hdl/bxx_queue.sv
// Short queue that decouples the front end from the cipher engine.
module bxx_queue import bxx_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  qword_t push_word,
	output logic   full,
	input  logic   pop,
	output logic   pop_valid,
	output qword_t pop_word
);

	localparam int DEPTH = 4;
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	qword_t        entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_word = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < CW'(DEPTH)))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue read while empty");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a lone write");

endmodule

>>> hdl/bxx_back.sv
// Cipher engine: loads a block into its store, runs the rounds one byte per cycle (none on pass-through), emits it.
module bxx_back import bxx_pkg::*; #(
	parameter int BLOCK_BYTES = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [31:0]  key,
	input  logic         q_valid,
	input  qword_t       q_word,
	output logic         pop,
	bxx_out_if.source    result_stream
);

	localparam int IDXW = $clog2(BLOCK_BYTES);
	localparam int CNTW = $clog2(BLOCK_BYTES + 1);
	localparam int ROUNDS = 6 + 52 / BLOCK_BYTES;
	localparam int RNDW = $clog2(ROUNDS);
	localparam int DELTA = 17;
	localparam logic [7:0] TEA_DELTA = 8'(DELTA);
	localparam logic [7:0] DEC_SUM = 8'((ROUNDS * DELTA) % 256);
	localparam logic [IDXW-1:0] LAST_IDX = IDXW'(BLOCK_BYTES - 1);
	localparam logic [IDXW-1:0] ENC_FIRST_RD = IDXW'(1);
	localparam logic [IDXW-1:0] DEC_FIRST_RD = IDXW'(BLOCK_BYTES - 2);
	localparam logic [RNDW-1:0] LAST_RND = RNDW'(ROUNDS - 1);
	localparam logic [CNTW-1:0] N_CNT = CNTW'(BLOCK_BYTES);
	localparam logic [CNTW-1:0] LAST_CNT = CNTW'(BLOCK_BYTES - 1);
	localparam logic [IDXW:0] N_EXT = (IDXW+1)'(BLOCK_BYTES);
	localparam logic [IDXW:0] TWO_EXT = (IDXW+1)'(2);

	typedef enum logic [1:0] {
		S_LOAD,
		S_PREP,
		S_RUN,
		S_EMIT
	} state_t;

	function automatic logic [7:0] tea_mix(input logic [7:0] y, input logic [7:0] z,
		input logic [7:0] sum, input logic [7:0] kb);
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
		logic [7:0] d;
		logic [7:0] ab;
		logic [7:0] cd;
		a = (z >> 5) ^ (y << 2);
		b = (y >> 3) ^ (z << 4);
		c = sum ^ y;
		d = kb ^ z;
		ab = a + b;
		cd = c + d;
		return ab ^ cd;
	endfunction

	logic [7:0] mem [BLOCK_BYTES];
	logic [7:0] rdata_q;

	state_t          state_q;
	op_t             op_q;
	logic [IDXW-1:0] p_q;
	logic [RNDW-1:0] rnd_q;
	logic [7:0]      sum_q;
	logic [7:0]      nb_q;
	logic [7:0]      v_q;
	logic [7:0]      first_q;
	logic [CNTW-1:0] kcnt_q;
	logic            rv_q;
	logic            rlast_q;
	logic            ov_q;
	logic [7:0]      obyte_q;
	logic            olast_q;

	logic            we;
	logic [IDXW-1:0] waddr;
	logic [7:0]      wdata;
	logic            re;
	logic [IDXW-1:0] raddr;
	logic            out_free;
	logic            move;
	logic            issue;
	logic [IDXW:0]   p_ext;
	logic [IDXW:0]   fwd2;
	logic [IDXW:0]   bwd2;
	logic [7:0]      mix_y;
	logic [7:0]      mix_z;
	logic [1:0]      kidx;
	logic [7:0]      kbyte;
	logic [7:0]      mixv;
	logic [7:0]      newv;

	assign result_stream.valid = ov_q;
	assign result_stream.out_byte = obyte_q;
	assign result_stream.last_of_block = olast_q;

	assign pop = (state_q == S_LOAD) && q_valid;

	always_comb begin
		p_ext = {1'b0, p_q};
		fwd2 = p_ext + TWO_EXT;
		if (fwd2 >= N_EXT) begin
			fwd2 = fwd2 - N_EXT;
		end
		if (p_ext < TWO_EXT) begin
			bwd2 = p_ext + N_EXT - TWO_EXT;
		end else begin
			bwd2 = p_ext - TWO_EXT;
		end
		mix_y = (op_q == OP_ENC) ? rdata_q : nb_q;
		mix_z = (op_q == OP_ENC) ? nb_q : rdata_q;
		kidx = p_q[1:0] ^ sum_q[3:2];
		kbyte = key[{kidx, 3'b000} +: 8];
		mixv = tea_mix(mix_y, mix_z, sum_q, kbyte);
		newv = (op_q == OP_ENC) ? (v_q + mixv) : (v_q - mixv);
	end

	always_comb begin
		we = 1'b0;
		waddr = p_q;
		wdata = newv;
		re = 1'b0;
		raddr = p_q;
		out_free = !ov_q || result_stream.ready;
		move = rv_q && out_free;
		issue = 1'b0;
		case (state_q)
			S_LOAD: begin
				we = q_valid;
				wdata = q_word.data;
			end
			S_PREP: begin
				re = 1'b1;
				raddr = (op_q == OP_ENC) ? ENC_FIRST_RD : DEC_FIRST_RD;
			end
			S_RUN: begin
				we = 1'b1;
				re = 1'b1;
				raddr = (op_q == OP_ENC) ? fwd2[IDXW-1:0] : bwd2[IDXW-1:0];
			end
			S_EMIT: begin
				issue = (kcnt_q != N_CNT) && (!rv_q || out_free);
				re = issue;
				raddr = kcnt_q[IDXW-1:0];
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			op_q    <= OP_PASS;
			p_q     <= '0;
			rnd_q   <= '0;
			sum_q   <= '0;
			nb_q    <= '0;
			v_q     <= '0;
			first_q <= '0;
			kcnt_q  <= '0;
			rv_q    <= 1'b0;
			rlast_q <= 1'b0;
			ov_q    <= 1'b0;
			obyte_q <= '0;
			olast_q <= 1'b0;
		end else begin
			if (move) begin
				ov_q    <= 1'b1;
				obyte_q <= rdata_q;
				olast_q <= rlast_q;
			end else if (result_stream.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (q_valid) begin
						if (p_q == '0) begin
							first_q <= q_word.data;
						end
						if (q_word.last) begin
							op_q   <= q_word.op;
							rnd_q  <= '0;
							kcnt_q <= '0;
							case (q_word.op)
								OP_ENC: begin
									nb_q    <= q_word.data;
									v_q     <= first_q;
									p_q     <= '0;
									sum_q   <= TEA_DELTA;
									state_q <= S_PREP;
								end
								OP_DEC: begin
									nb_q    <= first_q;
									v_q     <= q_word.data;
									p_q     <= LAST_IDX;
									sum_q   <= DEC_SUM;
									state_q <= S_PREP;
								end
								default: begin
									p_q     <= '0;
									state_q <= S_EMIT;
								end
							endcase
						end else begin
							p_q <= p_q + 1'b1;
						end
					end
				end
				S_PREP: begin
					state_q <= S_RUN;
				end
				S_RUN: begin
					v_q  <= rdata_q;
					nb_q <= newv;
					if (op_q == OP_ENC) begin
						if (p_q == LAST_IDX) begin
							p_q <= '0;
							if (rnd_q == LAST_RND) begin
								state_q <= S_EMIT;
							end else begin
								rnd_q <= rnd_q + 1'b1;
								sum_q <= sum_q + TEA_DELTA;
							end
						end else begin
							p_q <= p_q + 1'b1;
						end
					end else begin
						if (p_q == '0) begin
							p_q <= LAST_IDX;
							if (rnd_q == LAST_RND) begin
								state_q <= S_EMIT;
							end else begin
								rnd_q <= rnd_q + 1'b1;
								sum_q <= sum_q - TEA_DELTA;
							end
						end else begin
							p_q <= p_q - 1'b1;
						end
					end
				end
				S_EMIT: begin
					if (issue) begin
						kcnt_q  <= kcnt_q + 1'b1;
						rv_q    <= 1'b1;
						rlast_q <= (kcnt_q == LAST_CNT);
					end else if (move) begin
						rv_q <= 1'b0;
					end
					if ((kcnt_q == N_CNT) && !rv_q) begin
						p_q     <= '0;
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

>>> hdl/byte_xxtea_block_cipher.sv
// Top level: key register, front end, word queue and cipher engine.
// For encrypt or decrypt the engine runs ROUNDS = 6 + 52 / BLOCK_BYTES rounds
// over the block before its first result word; pass-through skips the rounds.
// Each block goes through load, rounds (one byte update per cycle, bound by the
// single read port of the block store) and emit; a new block is loaded only
// after the last one has been emitted.
// Reset is asynchronous and active low; it clears control state and restores
// the key to 0x92929392, while the block store keeps no reset value.
module byte_xxtea_block_cipher import bxx_pkg::*; #(
	parameter int BLOCK_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	bxx_in_if.sink      byte_stream,
	bxx_out_if.source   result_stream
);

	localparam logic [31:0] KEY_RESET = 32'h9292_9392;

	logic [31:0] cfg_key_q;
	logic        push;
	qword_t      push_word;
	logic        q_full;
	logic        pop;
	logic        q_valid;
	qword_t      q_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_key_q <= KEY_RESET;
		end else if (cfg_we) begin
			cfg_key_q <= cfg_wdata;
		end
	end

	bxx_front #(
		.BLOCK_BYTES(BLOCK_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_stream(byte_stream),
		.q_full     (q_full),
		.push       (push),
		.push_word  (push_word)
	);

	bxx_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_word(push_word),
		.full     (q_full),
		.pop      (pop),
		.pop_valid(q_valid),
		.pop_word (q_word)
	);

	bxx_back #(
		.BLOCK_BYTES(BLOCK_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.key          (cfg_key_q),
		.q_valid      (q_valid),
		.q_word       (q_word),
		.pop          (pop),
		.result_stream(result_stream)
	);

endmodule

>>> tb/byte_xxtea_block_cipher_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the byte-wide XXTEA block cipher with random handshake idling.
module byte_xxtea_block_cipher_tb;
	import bxx_pkg::*;

	localparam int BLK = 32;
	localparam int ROUNDS = 6 + 52 / BLK;
	localparam logic [7:0] DELTA = 8'h11;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [31:0] KEY_AT_RESET = 32'h9292_9392;
	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE = 2 * BLK;

	typedef logic [7:0] block_t [BLK];
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	bxx_in_if  byte_if();
	bxx_out_if res_if();

	byte_xxtea_block_cipher #(.BLOCK_BYTES(BLK)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.byte_stream(byte_if),
		.result_stream(res_if)
	);

	logic [7:0] cipher_store [BLK];
	int         store_fill = 0;
	logic [31:0] key_shadow = KEY_AT_RESET;
	result_t    expected_bytes [$];
	int         errors = 0;
	bit         sender_idles = 1'b0;
	bit         receiver_idles = 1'b0;
	int         quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [7:0] tea_mix(input logic [7:0] y, input logic [7:0] z,
		input logic [7:0] sum, input int p, input logic [1:0] e);
		logic [7:0] a, b, c, d, ab, cd;
		logic [1:0] ki;
		ki = p[1:0] ^ e;
		a = (z >> 5) ^ (y << 2);
		b = (y >> 3) ^ (z << 4);
		c = sum ^ y;
		d = key_shadow[8 * ki +: 8] ^ z;
		ab = a + b;
		cd = c + d;
		return ab ^ cd;
	endfunction

	function automatic void encipher_store();
		logic [7:0] sum;
		logic [1:0] e;
		int r, p;
		sum = 8'h00;
		for (r = 0; r < ROUNDS; r++) begin
			sum = sum + DELTA;
			e = sum[3:2];
			for (p = 0; p < BLK; p++) begin
				cipher_store[p] = cipher_store[p] + tea_mix(cipher_store[(p + 1) % BLK],
					cipher_store[(p + BLK - 1) % BLK], sum, p, e);
			end
		end
	endfunction

	function automatic void decipher_store();
		logic [7:0] sum;
		logic [1:0] e;
		int r, k, p;
		sum = 8'(ROUNDS * DELTA);
		for (r = 0; r < ROUNDS; r++) begin
			e = sum[3:2];
			for (k = 0; k < BLK; k++) begin
				p = BLK - 1 - k;
				cipher_store[p] = cipher_store[p] - tea_mix(cipher_store[(p + 1) % BLK],
					cipher_store[(p + BLK - 1) % BLK], sum, p, e);
			end
			sum = sum - DELTA;
		end
	endfunction

	// The word that completes a block selects the operation and releases all of its results.
	function automatic void absorb_byte(input logic [7:0] b, input logic [1:0] o);
		int i;
		cipher_store[store_fill] = b;
		if (store_fill < BLK - 1) begin
			store_fill++;
		end else begin
			store_fill = 0;
			if (o == OP_ENC) begin
				encipher_store();
			end else if (o == OP_DEC) begin
				decipher_store();
			end
			for (i = 0; i < BLK; i++) begin
				expected_bytes.push_back('{data: cipher_store[i], last: (i == BLK - 1)});
			end
		end
	endfunction

	function automatic block_t random_block();
		block_t v;
		foreach (v[i]) v[i] = 8'($urandom);
		return v;
	endfunction

	task automatic send_word(input logic [7:0] b, input logic [1:0] o);
		int gap;
		gap = sender_idles ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			byte_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_if.valid <= 1'b1;
		byte_if.in_byte <= b;
		byte_if.op <= o;
		do @(posedge clk); while (!byte_if.ready);
		absorb_byte(b, o);
	endtask

	task automatic send_block(input block_t blk, input logic [1:0] final_op);
		int i;
		for (i = 0; i < BLK; i++) begin
			send_word(blk[i], (i == BLK - 1) ? final_op : 2'($urandom_range(0, 3)));
		end
	endtask

	task automatic wait_drained();
		byte_if.valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_key(input logic [31:0] k);
		cfg_we <= 1'b1;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_we <= 1'b0;
		key_shadow = k;
	endtask

	task automatic test_directed_blocks();
		block_t blk;
		sender_idles = 1'b0;
		receiver_idles = 1'b0;
		foreach (blk[i]) blk[i] = 8'h00;
		send_block(blk, OP_ENC);
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		foreach (blk[i]) blk[i] = 8'(i * 9);
		send_block(blk, OP_UNUSED);
	endtask

	task automatic test_key_sweep();
		block_t blk;
		wait_drained();
		set_key(32'hFFFF_FFFF);
		sender_idles = ($urandom_range(0, 3) != 0);
		receiver_idles = ($urandom_range(0, 3) != 0);
		foreach (blk[i]) blk[i] = 8'hFF;
		send_block(blk, OP_DEC);
	endtask

	task automatic test_round_trip();
		block_t ct;
		wait_drained();
		set_key($urandom);
		sender_idles = 1'b1;
		receiver_idles = ($urandom_range(0, 1) != 0);
		send_block(random_block(), OP_ENC);
		foreach (ct[i]) ct[i] = cipher_store[i];
		send_block(ct, OP_DEC);
	endtask

	initial begin
		int stall;
		result_t want;
		res_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = receiver_idles ? $urandom_range(0, 9) : 0;
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
			if (expected_bytes.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, actual out_byte %02h last_of_block %0b",
					$time, res_if.out_byte, res_if.last_of_block);
			end else begin
				want = expected_bytes.pop_front();
				if (res_if.out_byte !== want.data) begin
					errors++;
					$display("%0t: out_byte expected %02h actual %02h",
						$time, want.data, res_if.out_byte);
				end
				if (res_if.last_of_block !== want.last) begin
					errors++;
					$display("%0t: last_of_block expected %0b actual %0b",
						$time, want.last, res_if.last_of_block);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
			$display("byte_xxtea_block_cipher verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 32'h0000_0000;
		byte_if.valid <= 1'b0;
		byte_if.in_byte <= 8'h00;
		byte_if.op <= OP_ENC;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed_blocks();
		test_key_sweep();
		test_round_trip();
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (errors == 0) begin
			$display("byte_xxtea_block_cipher verification clean");
		end else begin
			$display("byte_xxtea_block_cipher verification failed");
		end
		$finish;
	end

endmodule
